/* rtl/hsc_pkg.sv */
// ----------------------------------------------------------------------------
// Hex servo command parser package
// Character codes, the hex digit decoder and the line check result type.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] CHAN_A_CHAR  = 8'h41;
    localparam logic [7:0] CHAN_B_CHAR  = 8'h42;
    localparam logic [7:0] DIGIT_0_CHAR = 8'h30;
    localparam logic [7:0] DIGIT_9_CHAR = 8'h39;
    localparam logic [7:0] LOWER_A_CHAR = 8'h61;
    localparam logic [7:0] LOWER_F_CHAR = 8'h66;
    localparam logic [7:0] UPPER_F_CHAR = 8'h46;
    localparam logic [3:0] HEX_TEN      = 4'd10;

    localparam int unsigned SETTING_W = 16;

    typedef struct packed {
        logic                 ok;
        logic                 sel;
        logic [SETTING_W-1:0] value;
    } line_check_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        logic [7:0] diff;
        d    = '{ok: 1'b0, nibble: 4'd0};
        diff = 8'd0;
        if (c >= DIGIT_0_CHAR && c <= DIGIT_9_CHAR)
        begin
            diff = c - DIGIT_0_CHAR;
            d    = '{ok: 1'b1, nibble: diff[3:0]};
        end
        else if (c >= LOWER_A_CHAR && c <= LOWER_F_CHAR)
        begin
            diff = c - LOWER_A_CHAR;
            d    = '{ok: 1'b1, nibble: diff[3:0] + HEX_TEN};
        end
        else if (c >= CHAN_A_CHAR && c <= UPPER_F_CHAR)
        begin
            diff = c - CHAN_A_CHAR;
            d    = '{ok: 1'b1, nibble: diff[3:0] + HEX_TEN};
        end
        return d;
    endfunction

endpackage

/* rtl/hsc_line_check.sv */
// ----------------------------------------------------------------------------
// Hex servo command line check
// Checks a full stored line: channel letter first, hex digits after it.
// ----------------------------------------------------------------------------
module hsc_line_check #(
    parameter int LINE_LEN = 5
) (
    input  logic [7:0]           line_chars [LINE_LEN],
    output hsc_pkg::line_check_t check
);
    import hsc_pkg::*;

    hex_digit_t           digit [LINE_LEN];
    logic                 all_hex;
    logic [SETTING_W-1:0] value;

    always_comb
    begin
        all_hex  = 1'b1;
        value    = '0;
        digit[0] = hex_decode(line_chars[0]);
        for (int i = 1; i < LINE_LEN; i++)
        begin
            digit[i] = hex_decode(line_chars[i]);
            all_hex  = all_hex & digit[i].ok;
            value    = {value[SETTING_W-5:0], digit[i].nibble};
        end
    end

    always_comb
    begin
        check.sel   = (line_chars[0] == CHAN_B_CHAR);
        check.ok    = ((line_chars[0] == CHAN_A_CHAR) || (line_chars[0] == CHAN_B_CHAR))
                      && all_hex;
        check.value = value;
    end

endmodule

/* rtl/hex_servo_command_parser.sv */
// ----------------------------------------------------------------------------
// Hex servo command parser
// Collects received characters into a line and issues servo update requests.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one received character (rx_byte)
// per request. Characters other than newline are held until LINE_LEN have
// arrived; further ones mark the line as too long. A newline ends the line.
// Output channel: out_valid/out_ready carry one update request per valid
// line: servo_select (0 for 'A', 1 for 'B') and the 16-bit compare_setting
// from the hex digits. Bad or wrong-length lines are dropped silently.
// Throughput: one character per cycle when not stalled. Latency: the
// request appears in the cycle after the newline is accepted, from the
// output register fed by a single pass of line-check logic over the held
// characters. Stall: while a request waits on out_ready, in_ready is low
// and the next character waits; in_ready follows out_ready, so a request
// taken in a cycle frees the input in that same cycle.
// Reset: the character count and output valid clear; the block is ready
// from the first cycle after reset.
// ----------------------------------------------------------------------------
module hex_servo_command_parser #(
    parameter int LINE_LEN = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        servo_select,
    output logic [15:0] compare_setting
);
    import hsc_pkg::*;

    localparam int               CNT_W    = $clog2(LINE_LEN + 2);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LINE_LEN);
    localparam logic [CNT_W-1:0] OVER_CNT = CNT_W'(LINE_LEN + 1);

    logic [7:0]           char_store_reg [LINE_LEN];
    logic [CNT_W-1:0]     char_count_reg;
    logic [CNT_W-1:0]     char_count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 sel_reg;
    logic [SETTING_W-1:0] setting_reg;
    logic                 in_accept;
    logic                 is_newline;
    logic                 line_done;
    line_check_t          check;

    assign in_ready   = !out_valid_reg || out_ready;
    assign in_accept  = in_valid && in_ready;
    assign is_newline = (rx_byte == NEWLINE_CHAR);
    assign line_done  = in_accept && is_newline && (char_count_reg == FULL_CNT) && check.ok;

    hsc_line_check #(
        .LINE_LEN (LINE_LEN)
    ) u_line_check (
        .line_chars (char_store_reg),
        .check      (check)
    );

    always_comb
    begin
        char_count_next = char_count_reg;
        if (in_accept)
        begin
            if (is_newline)
                char_count_next = '0;
            else if (char_count_reg < FULL_CNT)
                char_count_next = char_count_reg + 1'b1;
            else
                char_count_next = OVER_CNT;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (line_done)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // hold the line as a shift line, oldest character at entry zero
    always_ff @(posedge clk)
    begin
        if (in_accept && !is_newline && (char_count_reg < FULL_CNT))
        begin
            for (int i = 0; i < LINE_LEN - 1; i++)
                char_store_reg[i] <= char_store_reg[i+1];
            char_store_reg[LINE_LEN-1] <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_done)
        begin
            sel_reg     <= check.sel;
            setting_reg <= check.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            char_count_reg <= char_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign servo_select    = sel_reg;
    assign compare_setting = setting_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg <= OVER_CNT)
        else $error("character count out of range");

    a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && is_newline |=> char_count_reg == '0)
        else $error("count not cleared after newline");

    a_count_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !is_newline && (char_count_reg < FULL_CNT)
        |=> char_count_reg == $past(char_count_reg) + 1'b1)
        else $error("count did not advance");

    a_request_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_accept && is_newline && char_count_reg == FULL_CNT))
        else $error("request raised without a complete line");
`endif

endmodule

/* bench/tb_hex_servo_command_parser.sv */
// ----------------------------------------------------------------------------
// Hex servo command parser testbench
// Sends command lines, some well formed and some broken, through the
// character channel. An internal line decoder predicts each servo update
// request, and every request taken from the block is checked against it.
// Idling on both sides and a long output hold-off give the handshakes a
// workout.
// ----------------------------------------------------------------------------
module tb_hex_servo_command_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import hsc_pkg::*;

    localparam int LINE_LEN = 5;
    localparam int COUNT_W  = $clog2(LINE_LEN + 2);

    typedef struct {
        logic        sel;
        logic [15:0] setting;
    } servo_update_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        servo_select;
    logic [15:0] compare_setting;

    logic [7:0]         held_chars [LINE_LEN] = '{default: 8'd0};
    logic [COUNT_W-1:0] held_count = '0;
    servo_update_t      updates_due [$];

    int unsigned chars_taken = 0;
    int unsigned fail_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;

    hex_servo_command_parser #(
        .LINE_LEN (LINE_LEN)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .servo_select    (servo_select),
        .compare_setting (compare_setting)
    );

    always #5 clk = ~clk;

    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] nib);
        nib = 4'd0;
        if (c >= DIGIT_0_CHAR && c <= DIGIT_9_CHAR)
        begin
            nib = c[3:0];
            return 1'b1;
        end
        if ((c >= LOWER_A_CHAR && c <= LOWER_F_CHAR) || (c >= CHAN_A_CHAR && c <= UPPER_F_CHAR))
        begin
            nib = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        servo_update_t upd;
        logic [3:0]    nib;
        logic          ok;
        if (c != NEWLINE_CHAR)
        begin
            if (held_count < LINE_LEN)
            begin
                held_chars[held_count] = c;
                held_count++;
            end
            else if (held_count == LINE_LEN)
                held_count++;
            return;
        end
        ok = (held_count == LINE_LEN)
            && (held_chars[0] == CHAN_A_CHAR || held_chars[0] == CHAN_B_CHAR);
        upd.sel = (held_chars[0] == CHAN_B_CHAR);
        upd.setting = 16'd0;
        for (int i = 1; i < LINE_LEN; i++)
        begin
            ok = ok & hex_nibble(held_chars[i], nib);
            upd.setting = {upd.setting[11:0], nib};
        end
        held_count = '0;
        if (ok)
            updates_due.push_back(upd);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < HEX_TEN)
            return DIGIT_0_CHAR + v;
        if ($urandom_range(1) == 1)
            return LOWER_A_CHAR + (v - HEX_TEN);
        return CHAN_A_CHAR + (v - HEX_TEN);
    endfunction

    always @(posedge clk)
    begin
        servo_update_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (updates_due.size() == 0)
            begin
                $error("update request with none due: servo_select %0d compare_setting %h",
                       servo_select, compare_setting);
                fail_count++;
            end
            else
            begin
                want = updates_due.pop_front();
                if (servo_select !== want.sel)
                begin
                    $error("servo_select: expected %0d, actual %0d", want.sel, servo_select);
                    fail_count++;
                end
                if (compare_setting !== want.setting)
                begin
                    $error("compare_setting: expected %h, actual %h",
                           want.setting, compare_setting);
                    fail_count++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            chars_taken++;
            take_char(rx_byte);
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_char(input logic [7:0] c);
        int unsigned seen;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= c;
        seen = chars_taken;
        @(negedge clk);
        while (chars_taken == seen)
            @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
        in_valid <= 1'b0;
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        @(negedge clk);
    endtask

    task automatic send_random_line();
        logic [7:0]  line_q [$];
        logic [7:0]  c;
        logic [3:0]  nib;
        int unsigned kind;
        int unsigned n;
        int unsigned pos;
        kind = $urandom_range(99);
        if (kind < 96 && !(kind >= 70 && kind < 80))
        begin
            line_q.push_back($urandom_range(1) ? CHAN_B_CHAR : CHAN_A_CHAR);
            for (int i = 1; i < LINE_LEN; i++)
                line_q.push_back(hex_char(4'($urandom_range(15))));
        end
        if (kind >= 70 && kind < 80)
        begin
            n = $urandom_range(2 * LINE_LEN - 1);
            for (int i = 0; i < n; i++)
                line_q.push_back(i == 0 ? ($urandom_range(1) ? CHAN_B_CHAR : CHAN_A_CHAR)
                                        : hex_char(4'($urandom_range(15))));
        end
        else if (kind >= 80 && kind < 88)
        begin
            do
                c = 8'($urandom_range(255));
            while (c == CHAN_A_CHAR || c == CHAN_B_CHAR || c == NEWLINE_CHAR);
            line_q[0] = c;
        end
        else if (kind >= 88 && kind < 96)
        begin
            do
                c = 8'($urandom_range(255));
            while (hex_nibble(c, nib) || c == NEWLINE_CHAR);
            pos = $urandom_range(LINE_LEN - 1, 1);
            line_q[pos] = c;
        end
        else if (kind >= 96)
        begin
            line_q = {};
            n = $urandom_range(8, 1);
            for (int i = 0; i < n; i++)
                line_q.push_back(8'($urandom_range(255)));
        end
        if (kind < 96)
            line_q.push_back(NEWLINE_CHAR);
        foreach (line_q[i])
            send_char(line_q[i]);
    endtask

    task automatic test_well_formed_lines();
        send_text("A0000\n");
        send_text("BFfFf\n");
    endtask

    task automatic test_wrong_length();
        send_text("\n");
        send_text("B1\n");
        send_text("A12345\n");
    endtask

    task automatic test_bad_letter();
        send_text("a1234\n");
    endtask

    task automatic test_bad_digit();
        send_text("A12g4\n");
        send_char(CHAN_B_CHAR);
        send_char(8'h80);
        send_char(8'hFF);
        send_text("00\n");
    endtask

    task automatic test_random_lines(input int unsigned send_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned lines);
        set_idling(send_pct, stall_pct);
        repeat (lines)
            send_random_line();
    endtask

    task automatic test_output_hold();
        set_idling(0, 0);
        @(posedge clk);
        hold_left = 120;
        @(negedge clk);
        repeat (14)
        begin
            send_char($urandom_range(1) ? CHAN_B_CHAR : CHAN_A_CHAR);
            repeat (LINE_LEN - 1)
                send_char(hex_char(4'($urandom_range(15))));
            send_char(NEWLINE_CHAR);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_well_formed_lines();
        test_wrong_length();
        test_bad_letter();
        test_bad_digit();
        test_random_lines(0, 0, 50);
        test_random_lines(45, 0, 50);
        test_random_lines(0, 45, 50);
        test_random_lines(16, 16, 50);
        test_output_hold();
        set_idling(0, 0);
        while (updates_due.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
